// File: design/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg: shared constants and types of the RSI stream block
// Field widths, fixed-point layout, divider sizing and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

   // Field widths.
   localparam int PRICE_W  = 32;
   localparam int PERIOD_W = 11;
   localparam int RSI_W    = 14;
   localparam int COUNT_W  = 11;

   // Fixed-point averages: 32 integer bits and FRACTION_BITS fraction bits.
   localparam int FRACTION_BITS = 16;
   localparam int AVG_W         = PRICE_W + FRACTION_BITS;

   // Period limits and reset value.
   localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(1024);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

   // The sample count saturates at its all-ones value.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Scale of the result: hundredths of a percent.
   localparam logic [RSI_W-1:0] RSI_SCALE = RSI_W'(10000);

   // avg*(n-1) with n-1 below 1024 needs ten more bits than an average.
   localparam int NM1_W     = PERIOD_W - 1;
   localparam int PROD_W    = AVG_W + NM1_W;
   // The divide by n retires two quotient bits a step.
   localparam int DIV_STEPS = (PROD_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;

   // Product and divisor of the ratio divide.
   localparam int RPROD_W = AVG_W + RSI_W;
   localparam int SUM_W   = AVG_W + 1;

   // Step counter of the controller covers both divides.
   localparam int MAX_STEPS = (DIV_STEPS > RSI_W) ? DIV_STEPS : RSI_W;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] RATIO_LAST = STEP_W'(RSI_W - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // input beat accepted this cycle
      logic mul;        // form avg*(n-1) products
      logic num_load;   // load the divide-by-n numerators
      logic div_step;   // one step of the divide by n
      logic acc;        // update both averages
      logic rmul;       // form 10000*G and G+L
      logic rload;      // load the ratio divider
      logic rstep;      // one step of the ratio divide
      logic out_write;  // write the result register
   } rsi_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic first;     // the beat offered now starts or restarts a series
      logic emit;      // the item in work produces a result
      logic zero_sum;  // both averages are zero
      logic out_free;  // the result register can take a new beat
   } rsi_status_type;

endpackage

// File: design/rsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_if: stream channels of the RSI block
// Valid/ready channels for close price beats and for RSI result beats.
// ----------------------------------------------------------------------------
interface rsi_req_if;
   import rsi_pkg::*;

   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] close_price;
   logic               restart;

   modport source (output valid, close_price, restart, input ready);
   modport sink   (input valid, close_price, restart, output ready);
endinterface

interface rsi_rsp_if;
   import rsi_pkg::*;

   logic             valid;
   logic             ready;
   logic [RSI_W-1:0] rsi_value;
   logic             undefined;

   modport source (output valid, rsi_value, undefined, input ready);
   modport sink   (input valid, rsi_value, undefined, output ready);
endinterface

// File: design/rsi_period_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_period_div: iterative divider by the period
// Restoring division of a wide numerator by an 11-bit period, two quotient
// bits per step. The numerator shifts out at the top while quotient bits
// shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
module rsi_period_div (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         step,
   input  logic [rsi_pkg::DIV_W-1:0]    numer,
   input  logic [rsi_pkg::PERIOD_W-1:0] divisor,
   output logic [rsi_pkg::AVG_W-1:0]    quotient
);
   import rsi_pkg::*;

   logic [DIV_W-1:0]    work_ff, work_in;
   logic [NM1_W-1:0]    rem_ff, rem_in;
   logic [PERIOD_W-1:0] trial_a, trial_b;
   logic [NM1_W-1:0]    rem_a;
   logic                bit_a, bit_b;

   // Two dependent restoring steps; the remainder always stays below the period.
   always_comb begin
      trial_a = {rem_ff, work_ff[DIV_W-1]};
      bit_a   = (trial_a >= divisor);
      rem_a   = bit_a ? NM1_W'(trial_a - divisor) : NM1_W'(trial_a);
      trial_b = {rem_a, work_ff[DIV_W-2]};
      bit_b   = (trial_b >= divisor);
      work_in = work_ff;
      rem_in  = rem_ff;
      if (load) begin
         work_in = numer;
         rem_in  = '0;
      end else if (step) begin
         work_in = {work_ff[DIV_W-3:0], bit_a, bit_b};
         rem_in  = bit_b ? NM1_W'(trial_b - divisor) : NM1_W'(trial_b);
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   // The quotient of an average update always fits an average.
   assign quotient = work_ff[AVG_W-1:0];

endmodule

// File: design/rsi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ctrl: sequencer of the RSI block
// Walks one item through the products, the divide by the period, the
// average update, the ratio divide and the write of the result register.
// ----------------------------------------------------------------------------
module rsi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rsi_pkg::rsi_status_type status,
   output rsi_pkg::rsi_cmd_type    cmd
);
   import rsi_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_RMUL  = 4'd5;
   localparam logic [3:0] S_RLOAD = 4'd6;
   localparam logic [3:0] S_RDIV  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state, step counter and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.first) begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.num_load = 1'b1;
            step_in      = DIV_LAST;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_ACC;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_RMUL;
         end
         S_RMUL: begin
            // Items that produce no result end here.
            if (!status.emit) begin
               state_in = S_IDLE;
            end else begin
               cmd.rmul = 1'b1;
               state_in = status.zero_sum ? S_OUT : S_RLOAD;
            end
         end
         S_RLOAD: begin
            cmd.rload = 1'b1;
            step_in   = RATIO_LAST;
            state_in  = S_RDIV;
         end
         S_RDIV: begin
            cmd.rstep = 1'b1;
            if (step_ff == '0) begin
               state_in = S_OUT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: design/rsi_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_dpath: datapath of the RSI block
// Holds the period, the series state and both averages, forms the
// smoothing numerators, divides them by the period, runs the ratio divide
// and keeps the result register.
// ----------------------------------------------------------------------------
module rsi_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  rsi_pkg::rsi_cmd_type         cmd,
   output rsi_pkg::rsi_status_type      status,
   input  logic                         csr_write_en,
   input  logic [rsi_pkg::PERIOD_W-1:0] csr_write_data,
   input  logic [rsi_pkg::PRICE_W-1:0]  req_close_price,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rsi_pkg::RSI_W-1:0]    rsp_rsi_value,
   output logic                         rsp_undefined
);
   import rsi_pkg::*;

   // Configuration and series state.
   logic [PERIOD_W-1:0] period_ff;
   logic [PRICE_W-1:0]  prev_ff, prev_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [AVG_W-1:0]    avg_g_ff, avg_g_in, avg_l_ff, avg_l_in;

   // Per-item working registers.
   logic [PERIOD_W-1:0] n_ff, n_in, n_eff;
   logic [NM1_W-1:0]    nm1_ff;
   logic [PRICE_W-1:0]  delta_ff, delta_in;
   logic                up_ff, up_in;
   logic                smooth_ff, smooth_in;
   logic                emit_ff, emit_in;
   logic [COUNT_W-1:0]  cnt_eff;
   logic [PROD_W-1:0]   prod_g_ff, prod_l_ff;
   logic [AVG_W-1:0]    x_gain, x_loss;
   logic [DIV_W-1:0]    numer_g, numer_l;
   logic [AVG_W-1:0]    quot_g, quot_l;

   // Ratio divide.
   logic [RPROD_W-1:0]  rprod_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    rrem_ff, rrem_in;
   logic [RSI_W-1:0]    rlow_ff, rlow_in;
   logic [SUM_W:0]      rtrial;
   logic                rbit;
   logic                undef_ff;

   // Result register.
   logic                out_valid_ff;
   logic [RSI_W-1:0]    out_rsi_ff;
   logic                out_undef_ff;

   // Period register.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write_en) begin
         period_ff <= csr_write_data;
      end
   end

   // Out-of-range periods are clamped.
   always_comb begin
      if (period_ff < PERIOD_MIN) begin
         n_eff = PERIOD_MIN;
      end else if (period_ff > PERIOD_MAX) begin
         n_eff = PERIOD_MAX;
      end else begin
         n_eff = period_ff;
      end
   end

   // A restart clears the count, so the offered close starts a new series.
   assign cnt_eff = req_restart ? '0 : count_ff;

   // Series state update at the accepted beat and at the average update.
   always_comb begin
      prev_in   = prev_ff;
      count_in  = count_ff;
      avg_g_in  = avg_g_ff;
      avg_l_in  = avg_l_ff;
      delta_in  = delta_ff;
      up_in     = up_ff;
      smooth_in = smooth_ff;
      emit_in   = emit_ff;
      n_in      = n_ff;
      if (cmd.load) begin
         prev_in   = req_close_price;
         up_in     = (req_close_price > prev_ff);
         delta_in  = up_in ? (req_close_price - prev_ff) : (prev_ff - req_close_price);
         smooth_in = (cnt_eff >= n_eff);
         emit_in   = smooth_in || (cnt_eff == (n_eff - 1'b1));
         n_in      = n_eff;
         if (req_restart) begin
            avg_g_in = '0;
            avg_l_in = '0;
         end
         if (cnt_eff == '0) begin
            count_in = COUNT_W'(1);
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.acc) begin
         if (smooth_ff) begin
            avg_g_in = quot_g;
            avg_l_in = quot_l;
         end else begin
            avg_g_in = avg_g_ff + quot_g;
            avg_l_in = avg_l_ff + quot_l;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         count_ff <= '0;
         avg_g_ff <= '0;
         avg_l_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
         avg_g_ff <= avg_g_in;
         avg_l_ff <= avg_l_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      up_ff     <= up_in;
      smooth_ff <= smooth_in;
      emit_ff   <= emit_in;
      n_ff      <= n_in;
      if (cmd.load) begin
         nm1_ff <= NM1_W'(n_eff - 1'b1);
      end
   end

   // Scaled gain and loss of this step; at most one of them is nonzero.
   assign x_gain = up_ff ? {delta_ff, {FRACTION_BITS{1'b0}}} : '0;
   assign x_loss = up_ff ? '0 : {delta_ff, {FRACTION_BITS{1'b0}}};

   // Smoothing products avg*(n-1), registered before the add.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_g_ff <= PROD_W'(avg_g_ff) * PROD_W'(nm1_ff);
         prod_l_ff <= PROD_W'(avg_l_ff) * PROD_W'(nm1_ff);
      end
   end

   // Numerators: avg*(n-1)+x when smoothing, x alone during warm-up.
   always_comb begin
      if (smooth_ff) begin
         numer_g = DIV_W'(prod_g_ff) + DIV_W'(x_gain);
         numer_l = DIV_W'(prod_l_ff) + DIV_W'(x_loss);
      end else begin
         numer_g = DIV_W'(x_gain);
         numer_l = DIV_W'(x_loss);
      end
   end

   rsi_period_div u_div_gain (
      .clock    (clock),
      .load     (cmd.num_load),
      .step     (cmd.div_step),
      .numer    (numer_g),
      .divisor  (n_ff),
      .quotient (quot_g)
   );

   rsi_period_div u_div_loss (
      .clock    (clock),
      .load     (cmd.num_load),
      .step     (cmd.div_step),
      .numer    (numer_l),
      .divisor  (n_ff),
      .quotient (quot_l)
   );

   // Ratio divide of 10000*G by G+L; the quotient stays below 2^14, so the
   // upper product bits already form a remainder below the divisor.
   always_comb begin
      rtrial  = {rrem_ff, rlow_ff[RSI_W-1]};
      rbit    = (rtrial >= {1'b0, sum_ff});
      rrem_in = rrem_ff;
      rlow_in = rlow_ff;
      if (cmd.rload) begin
         rrem_in = SUM_W'(rprod_ff[RPROD_W-1:RSI_W]);
         rlow_in = rprod_ff[RSI_W-1:0];
      end else if (cmd.rstep) begin
         rrem_in = rbit ? SUM_W'(rtrial - {1'b0, sum_ff}) : SUM_W'(rtrial);
         rlow_in = {rlow_ff[RSI_W-2:0], rbit};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rmul) begin
         rprod_ff <= RPROD_W'(avg_g_ff) * RPROD_W'(RSI_SCALE);
         sum_ff   <= SUM_W'(avg_g_ff) + SUM_W'(avg_l_ff);
         undef_ff <= status.zero_sum;
      end
      rrem_ff <= rrem_in;
      rlow_ff <= rlow_in;
   end

   // Result register: a new beat may be written as the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_write) begin
         out_rsi_ff   <= undef_ff ? '0 : rlow_ff;
         out_undef_ff <= undef_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_rsi_value = out_rsi_ff;
   assign rsp_undefined = out_undef_ff;

   // Status to the controller.
   always_comb begin
      status.first    = (cnt_eff == '0);
      status.emit     = emit_ff;
      status.zero_sum = (avg_g_ff == '0) && (avg_l_ff == '0);
      status.out_free = !out_valid_ff || rsp_ready;
   end

endmodule

// File: design/rsi_wilder_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_wilder_stream: relative strength index with Wilder smoothing
// Takes one closing price per beat, keeps fixed-point average gain and loss
// and emits the RSI in hundredths of a percent once the series has warmed up.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload                          Beat
//   req_chan   in         close_price[31:0], restart       valid & ready
//   rsp_chan   out        rsi_value[13:0], undefined       valid & ready
//   csr_*      in         write_data[10:0] (period)        write_en
//
// A close that starts a series is only loaded into the series state. Any
// other close runs the products, the divide by the period that retires two
// bits a cycle on averages with 16 fraction bits, and the average update; a
// close that produces a result then runs the 14-step ratio divide and the
// result write, or only the write when both averages are zero.
// Reset is synchronous and restores period 14 and an empty series. The
// result register holds one beat; while it is stalled, the next result waits
// in the sequencer and no new close is accepted until the register frees up.
// ----------------------------------------------------------------------------
module rsi_wilder_stream (
   input  logic                         clock,
   input  logic                         reset,
   rsi_req_if.sink                      req_chan,
   rsi_rsp_if.source                    rsp_chan,
   input  logic                         csr_write_en,
   input  logic [rsi_pkg::PERIOD_W-1:0] csr_write_data
);
   import rsi_pkg::*;

   rsi_cmd_type    cmd;
   rsi_status_type status;
   logic           ready;
   logic           out_valid;
   logic [RSI_W-1:0] out_rsi;
   logic           out_undef;

   rsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsi_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_close_price (req_chan.close_price),
      .req_restart     (req_chan.restart),
      .rsp_valid       (out_valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_rsi_value   (out_rsi),
      .rsp_undefined   (out_undef)
   );

   assign req_chan.ready     = ready;
   assign rsp_chan.valid     = out_valid;
   assign rsp_chan.rsi_value = out_rsi;
   assign rsp_chan.undefined = out_undef;

endmodule
